// ===== rtl/bsp_pkg.sv =====
// Shared types and constants for the block sum pooling design.
package bsp_pkg;

   localparam int SUM_W      = 22;
   localparam int COL_OUT_W  = 10;
   localparam int RATIO_W    = 4;
   localparam int DIM_W      = 11;
   localparam int ROW_W      = 10;
   localparam int MAX_HEIGHT = 1024;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 4;

   typedef enum logic [1:0] {
      REG_RATIO         = 2'd0,
      REG_COARSE_WIDTH  = 2'd1,
      REG_COARSE_HEIGHT = 2'd2
   } csr_index_type;

endpackage

// ===== rtl/block_sum_pooling.sv =====
// Block sum pooling: non-overlapping ratio-by-ratio sums over a raster stream.
// A sample that closes a block passes the line memory stage, then the result register.
// One sample per cycle unless stalled; line memory read and write-back sit one stage apart.
// Stalls back up through a single hold stage in front of the result register.
// Reset is synchronous: counters, partial sum, configuration registers and valid flags return
// to their defaults; the line memory is not cleared, its data used only once written.
module block_sum_pooling
   import bsp_pkg::*;
#(
   parameter int MAX_WIDTH = 1024,
   parameter int MAX_RATIO = 8,
   parameter int DATA_BITS = 16
) (
   input  logic                         clock,
   input  logic                         reset,

   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic signed [DATA_BITS-1:0]  req_grad_value,

   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic signed [SUM_W-1:0]      rsp_block_sum,
   output logic        [COL_OUT_W-1:0]  rsp_coarse_col,
   output logic                         rsp_channel_end,

   input  logic                         psel,
   input  logic                         penable,
   input  logic                         pwrite,
   input  logic [CSR_ADDR_W-1:0]        paddr,
   input  logic [CSR_DATA_W-1:0]        pwdata,
   output logic [CSR_DATA_W-1:0]        prdata,
   output logic                         pready
);

   localparam int COL_W = $clog2(MAX_WIDTH);
   localparam int WW    = $clog2(MAX_WIDTH + 1);
   localparam int SC_W  = $clog2(MAX_RATIO);
   localparam int RW    = $clog2(MAX_RATIO + 1);

   // configuration registers
   logic [RATIO_W-1:0] ratio_ff;
   logic [DIM_W-1:0]   coarse_width_ff;
   logic [DIM_W-1:0]   coarse_height_ff;
   csr_index_type      csr_index;
   logic               csr_write;

   assign pready    = 1'b1;
   assign csr_index = csr_index_type'(paddr[3:2]);
   assign csr_write = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         ratio_ff         <= RATIO_W'(2);
         coarse_width_ff  <= DIM_W'(64);
         coarse_height_ff <= DIM_W'(64);
      end else if (csr_write) begin
         case (csr_index)
            REG_RATIO:         ratio_ff         <= pwdata[RATIO_W-1:0];
            REG_COARSE_WIDTH:  coarse_width_ff  <= pwdata[DIM_W-1:0];
            REG_COARSE_HEIGHT: coarse_height_ff <= pwdata[DIM_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         REG_RATIO:         prdata = CSR_DATA_W'(ratio_ff);
         REG_COARSE_WIDTH:  prdata = CSR_DATA_W'(coarse_width_ff);
         REG_COARSE_HEIGHT: prdata = CSR_DATA_W'(coarse_height_ff);
         default:           prdata = '0;
      endcase
   end

   // clamped sizes
   logic [RW-1:0]    r_eff;
   logic [WW-1:0]    w_eff;
   logic [DIM_W-1:0] h_eff;

   always_comb begin
      if (ratio_ff == '0)
         r_eff = RW'(1);
      else if (32'(ratio_ff) > 32'(MAX_RATIO))
         r_eff = RW'(MAX_RATIO);
      else
         r_eff = RW'(ratio_ff);

      if (coarse_width_ff == '0)
         w_eff = WW'(1);
      else if (32'(coarse_width_ff) > 32'(MAX_WIDTH))
         w_eff = WW'(MAX_WIDTH);
      else
         w_eff = WW'(coarse_width_ff);

      if (coarse_height_ff == '0)
         h_eff = DIM_W'(1);
      else if (32'(coarse_height_ff) > 32'(MAX_HEIGHT))
         h_eff = DIM_W'(MAX_HEIGHT);
      else
         h_eff = coarse_height_ff;
   end

   // position counters and running row sum
   logic [SUM_W-1:0] run_sum_ff;
   logic [SC_W-1:0]  sub_col_ff;
   logic [SC_W-1:0]  sub_row_ff;
   logic [COL_W-1:0] col_count_ff;
   logic [ROW_W-1:0] row_count_ff;

   logic [SUM_W-1:0] sample;
   logic [SUM_W-1:0] part_in;
   logic [RW-1:0]    sub_col_inc;
   logic [RW-1:0]    sub_row_inc;
   logic [WW-1:0]    col_inc;
   logic [DIM_W-1:0] row_inc;
   logic             done;
   logic             last_row;
   logic             last_col;
   logic             last_chan_row;
   logic             accept;

   assign sample        = SUM_W'(req_grad_value);
   assign part_in       = run_sum_ff + sample;
   assign sub_col_inc   = RW'(sub_col_ff) + RW'(1);
   assign sub_row_inc   = RW'(sub_row_ff) + RW'(1);
   assign col_inc       = WW'(col_count_ff) + WW'(1);
   assign row_inc       = DIM_W'(row_count_ff) + DIM_W'(1);
   assign done          = sub_col_inc >= r_eff;
   assign last_row      = sub_row_inc >= r_eff;
   assign last_col      = col_inc >= w_eff;
   assign last_chan_row = row_inc >= h_eff;
   assign accept        = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         run_sum_ff   <= '0;
         sub_col_ff   <= '0;
         sub_row_ff   <= '0;
         col_count_ff <= '0;
         row_count_ff <= '0;
      end else if (accept) begin
         if (!done) begin
            run_sum_ff <= part_in;
            sub_col_ff <= sub_col_inc[SC_W-1:0];
         end else begin
            run_sum_ff <= '0;
            sub_col_ff <= '0;
            if (last_col) begin
               col_count_ff <= '0;
               if (last_row) begin
                  sub_row_ff   <= '0;
                  row_count_ff <= last_chan_row ? '0 : row_inc[ROW_W-1:0];
               end else begin
                  sub_row_ff <= sub_row_inc[SC_W-1:0];
               end
            end else begin
               col_count_ff <= col_inc[COL_W-1:0];
            end
         end
      end
   end

   // line memory stage: read on transfer, add and write back when the registered stage retires
   logic [SUM_W-1:0] line_mem [MAX_WIDTH];
   logic [SUM_W-1:0] rd_data_ff;
   logic             a_valid_ff;
   logic             a_emit_ff;
   logic             a_first_ff;
   logic             a_end_ff;
   logic [COL_W-1:0] a_col_ff;
   logic [SUM_W-1:0] a_part_ff;
   logic             fwd_ff;
   logic [SUM_W-1:0] fwd_data_ff;

   logic             a_hold;
   logic             a_retire;
   logic [SUM_W-1:0] base;
   logic [SUM_W-1:0] block_sum;

   assign a_hold    = a_valid_ff && a_emit_ff && rsp_valid && rsp_stall;
   assign a_retire  = a_valid_ff && !a_hold;
   assign req_stall = a_hold;

   always_comb begin
      if (a_first_ff)
         base = '0;
      else if (fwd_ff)
         base = fwd_data_ff;
      else
         base = rd_data_ff;
      block_sum = base + a_part_ff;
   end

   always_ff @(posedge clock) begin
      if (a_retire)
         line_mem[a_col_ff] <= block_sum;
      if (accept)
         rd_data_ff <= line_mem[col_count_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         fwd_ff     <= 1'b0;
      end else if (accept) begin
         a_valid_ff <= done;
         fwd_ff     <= a_valid_ff && (a_col_ff == col_count_ff);
      end else if (!a_hold) begin
         a_valid_ff <= 1'b0;
         fwd_ff     <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         a_emit_ff   <= last_row;
         a_first_ff  <= sub_row_ff == '0;
         a_end_ff    <= last_col && last_chan_row;
         a_col_ff    <= col_count_ff;
         a_part_ff   <= part_in;
         fwd_data_ff <= block_sum;
      end
   end

   // result register
   logic                 rsp_valid_ff;
   logic [SUM_W-1:0]     rsp_sum_ff;
   logic [COL_OUT_W-1:0] rsp_col_ff;
   logic                 rsp_end_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (a_retire && a_emit_ff) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (a_retire && a_emit_ff) begin
         rsp_sum_ff <= block_sum;
         rsp_col_ff <= COL_OUT_W'(a_col_ff);
         rsp_end_ff <= a_end_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_block_sum   = rsp_sum_ff;
   assign rsp_coarse_col  = rsp_col_ff;
   assign rsp_channel_end = rsp_end_ff;

endmodule
